/* sv/tclp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tclp_pkg
// Shared types, character codes and keyword tables for the time command
// line parser.
// ----------------------------------------------------------------------------
package tclp_pkg;

    localparam int LINE_BUFFER_BYTES = 64;
    localparam int COUNT_W           = $clog2(LINE_BUFFER_BYTES);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(LINE_BUFFER_BYTES - 1);

    localparam int SLOT_COUNT = 5;

    localparam logic [4:0] DATETIME_CHARS = 5'd19;
    localparam logic [4:0] YEAR_DIGITS    = 5'd4;
    localparam logic [4:0] POS_DASH_1     = 5'd4;
    localparam logic [4:0] POS_DASH_2     = 5'd7;
    localparam logic [4:0] POS_DATE_SEP   = 5'd10;
    localparam logic [4:0] POS_COLON_1    = 5'd13;
    localparam logic [4:0] POS_COLON_2    = 5'd16;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_I   = 8'h49;
    localparam logic [7:0] CH_UP_M   = 8'h4D;
    localparam logic [7:0] CH_UP_S   = 8'h53;
    localparam logic [7:0] CH_UP_T   = 8'h54;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    localparam logic KW_TIME    = 1'b0;
    localparam logic KW_SETTIME = 1'b1;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_KW,
        PH_KW_DONE,
        PH_SEP,
        PH_POST_EQ,
        PH_PAYLOAD,
        PH_TAIL,
        PH_NOTCMD
    } t_phase;

    typedef enum logic [1:0] {
        ST_NOT_CMD,
        ST_BAD_FORMAT,
        ST_PARSED,
        ST_OVERFLOW
    } t_status;

    typedef struct packed {
        logic        report;
        t_status     status;
        logic        settime;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic        ok;
    } t_result;

    function automatic logic [2:0] kw_len(input logic kind);
        return (kind == KW_SETTIME) ? 3'd7 : 3'd4;
    endfunction

    function automatic logic [7:0] kw_char(input logic kind, input logic [2:0] idx);
        logic [7:0] ch;
        ch = CH_NUL;
        if (kind == KW_TIME) begin
            case (idx)
                3'd0:    ch = CH_UP_T;
                3'd1:    ch = CH_UP_I;
                3'd2:    ch = CH_UP_M;
                3'd3:    ch = CH_UP_E;
                default: ch = CH_NUL;
            endcase
        end else begin
            case (idx)
                3'd0:    ch = CH_UP_S;
                3'd1:    ch = CH_UP_E;
                3'd2:    ch = CH_UP_T;
                3'd3:    ch = CH_UP_T;
                3'd4:    ch = CH_UP_I;
                3'd5:    ch = CH_UP_M;
                3'd6:    ch = CH_UP_E;
                default: ch = CH_NUL;
            endcase
        end
        return ch;
    endfunction

    // two-digit field slot for a payload position
    function automatic logic [2:0] acc_slot(input logic [4:0] pos);
        logic [2:0] s;
        case (pos)
            5'd5, 5'd6:   s = 3'd0;
            5'd8, 5'd9:   s = 3'd1;
            5'd11, 5'd12: s = 3'd2;
            5'd14, 5'd15: s = 3'd3;
            5'd17, 5'd18: s = 3'd4;
            default:      s = 3'd0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

/* sv/tclp_parse.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tclp_parse
// Line grammar state and per-byte update; gives the line report for the
// byte presented and commits the new state on a step.
// ----------------------------------------------------------------------------
module tclp_parse (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_byte,
    output tclp_pkg::t_result      o_res
);
    import tclp_pkg::*;

    logic [COUNT_W-1:0] r_count,  n_count;
    t_phase             r_phase,  n_phase;
    logic [2:0]         r_kw_idx, n_kw_idx;
    logic               r_kind,   n_kind;
    logic [4:0]         r_pos,    n_pos;
    logic               r_ended,  n_ended;
    logic               r_err,    n_err;
    logic [13:0]        r_year,   n_year;
    logic [6:0]         r_acc [SLOT_COUNT];
    logic [6:0]         n_acc [SLOT_COUNT];

    logic [7:0] upper;
    logic       blank;
    logic       is_digit;
    logic [3:0] digit;
    logic       do_payload;
    logic       pay_ok;
    logic [2:0] slot;
    t_result    res;

    always_comb begin
        upper      = (i_byte >= CH_LOW_A && i_byte <= CH_LOW_Z) ? (i_byte - CASE_GAP) : i_byte;
        blank      = (i_byte == CH_SPACE) || (i_byte == CH_TAB);
        is_digit   = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        digit      = i_byte[3:0];
        slot       = acc_slot(r_pos);
        do_payload = 1'b0;
        pay_ok     = 1'b0;

        n_count  = r_count;
        n_phase  = r_phase;
        n_kw_idx = r_kw_idx;
        n_kind   = r_kind;
        n_pos    = r_pos;
        n_ended  = r_ended;
        n_err    = r_err;
        n_year   = r_year;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            n_acc[k] = r_acc[k];
        end

        res        = '0;
        res.status = ST_NOT_CMD;

        if (i_byte == CH_CR) begin
            // ignored
        end else if (i_byte == CH_LF) begin
            if (r_count != '0) begin
                res.report = 1'b1;
                case (r_phase)
                    PH_KW_DONE, PH_SEP, PH_POST_EQ, PH_PAYLOAD: res.status = ST_BAD_FORMAT;
                    PH_TAIL:  res.status = r_err ? ST_BAD_FORMAT : ST_PARSED;
                    default:  res.status = ST_NOT_CMD;
                endcase
                if (res.status != ST_NOT_CMD) begin
                    res.settime = r_kind;
                end
                if (res.status == ST_PARSED) begin
                    res.year   = r_year;
                    res.month  = r_acc[0];
                    res.day    = r_acc[1];
                    res.hour   = r_acc[2];
                    res.minute = r_acc[3];
                    res.second = r_acc[4];
                    res.ok     = 1'b1;
                end
            end
        end else if (r_count < COUNT_MAX) begin
            n_count = r_count + 1'b1;
            if (!r_ended) begin
                if (i_byte == CH_NUL) begin
                    n_ended = 1'b1;
                end else begin
                    case (r_phase)
                        PH_LEAD: begin
                            if (!blank) begin
                                if (upper == CH_UP_T) begin
                                    n_kind   = KW_TIME;
                                    n_kw_idx = 3'd1;
                                    n_phase  = PH_KW;
                                end else if (upper == CH_UP_S) begin
                                    n_kind   = KW_SETTIME;
                                    n_kw_idx = 3'd1;
                                    n_phase  = PH_KW;
                                end else begin
                                    n_phase = PH_NOTCMD;
                                end
                            end
                        end
                        PH_KW: begin
                            if (r_kw_idx < kw_len(r_kind)
                                    && upper == kw_char(r_kind, r_kw_idx)) begin
                                n_kw_idx = r_kw_idx + 3'd1;
                                if (n_kw_idx >= kw_len(r_kind)) begin
                                    n_phase = PH_KW_DONE;
                                end
                            end else begin
                                n_phase = PH_NOTCMD;
                            end
                        end
                        PH_KW_DONE: begin
                            if (blank) begin
                                n_phase = PH_SEP;
                            end else if (i_byte == CH_EQUALS) begin
                                n_phase = PH_POST_EQ;
                            end else begin
                                n_phase = PH_NOTCMD;
                            end
                        end
                        PH_SEP: begin
                            if (i_byte == CH_EQUALS) begin
                                n_phase = PH_POST_EQ;
                            end else if (!blank) begin
                                n_phase    = PH_PAYLOAD;
                                do_payload = 1'b1;
                            end
                        end
                        PH_POST_EQ: begin
                            if (!blank) begin
                                n_phase    = PH_PAYLOAD;
                                do_payload = 1'b1;
                            end
                        end
                        PH_PAYLOAD: begin
                            do_payload = 1'b1;
                        end
                        PH_TAIL: begin
                            if (!blank) begin
                                n_err = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (do_payload) begin
                        case (r_pos)
                            POS_DASH_1, POS_DASH_2:   pay_ok = (i_byte == CH_DASH);
                            POS_DATE_SEP:             pay_ok = blank ? (i_byte == CH_SPACE)
                                                                     : (i_byte == CH_UP_T);
                            POS_COLON_1, POS_COLON_2: pay_ok = (i_byte == CH_COLON);
                            default: begin
                                pay_ok = is_digit;
                                if (is_digit) begin
                                    if (r_pos < YEAR_DIGITS) begin
                                        n_year = (r_year << 3) + (r_year << 1) + {10'd0, digit};
                                    end else begin
                                        n_acc[slot] = (r_acc[slot] << 3) + (r_acc[slot] << 1)
                                                    + {3'd0, digit};
                                    end
                                end
                            end
                        endcase
                        if (!pay_ok) begin
                            n_err = 1'b1;
                        end
                        n_pos = r_pos + 5'd1;
                        if (n_pos >= DATETIME_CHARS) begin
                            n_phase = PH_TAIL;
                        end
                    end
                end
            end
        end else begin
            res.report = 1'b1;
            res.status = ST_OVERFLOW;
        end

        // line ends: back to an empty line
        if (res.report) begin
            n_count  = '0;
            n_phase  = PH_LEAD;
            n_kw_idx = '0;
            n_kind   = 1'b0;
            n_pos    = '0;
            n_ended  = 1'b0;
            n_err    = 1'b0;
            n_year   = '0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                n_acc[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_phase  <= PH_LEAD;
            r_kw_idx <= '0;
            r_kind   <= 1'b0;
            r_pos    <= '0;
            r_ended  <= 1'b0;
            r_err    <= 1'b0;
            r_year   <= '0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_acc[k] <= '0;
            end
        end else if (i_step) begin
            r_count  <= n_count;
            r_phase  <= n_phase;
            r_kw_idx <= n_kw_idx;
            r_kind   <= n_kind;
            r_pos    <= n_pos;
            r_ended  <= n_ended;
            r_err    <= n_err;
            r_year   <= n_year;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_acc[k] <= n_acc[k];
            end
        end
    end

    assign o_res = res;

endmodule
`default_nettype wire

/* sv/time_command_line_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// time_command_line_parser
// Serial line parser for TIME / SETTIME date-time commands.
// ----------------------------------------------------------------------------
// input channel: one received byte per request on i_data_byte (i_valid/o_ready)
// output channel: one report per non-empty line or overflow (o_valid/i_ready)
//   with status, keyword kind, the six date and time fields and message_ok
// a byte is held in the input register while the grammar update works on it;
//   a report is registered in the output register from the newline (or
//   overflowing byte) in the input register when that byte steps
// throughput: one byte per cycle unless a byte that would give a report stalls
// carriage returns, empty lines and ordinary characters give no report
// a pending report does not block bytes that give no report; a byte that
//   would give a second report waits in the input register until the first
//   is taken, and o_ready drops only then
// reset: both registers empty, line state cleared to an empty line
// ----------------------------------------------------------------------------
module time_command_line_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_line_status,
    output logic             o_keyword_is_settime,
    output logic [13:0]      o_year_value,
    output logic [6:0]       o_month_value,
    output logic [6:0]       o_day_value,
    output logic [6:0]       o_hour_value,
    output logic [6:0]       o_minute_value,
    output logic [6:0]       o_second_value,
    output logic             o_message_ok
);
    import tclp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    res;
    logic       stall;
    logic       step;

    tclp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    assign stall   = r_in_valid && res.report && r_out_valid && !i_ready;
    assign step    = r_in_valid && !stall;
    assign o_ready = !r_in_valid || !stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res.report) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.report) begin
            r_out <= res;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_line_status        = r_out.status;
    assign o_keyword_is_settime = r_out.settime;
    assign o_year_value         = r_out.year;
    assign o_month_value        = r_out.month;
    assign o_day_value          = r_out.day;
    assign o_hour_value         = r_out.hour;
    assign o_minute_value       = r_out.minute;
    assign o_second_value       = r_out.second;
    assign o_message_ok         = r_out.ok;

endmodule
`default_nettype wire

/* sv/tclp_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tclp_checker
// Port-level checks on the parser's report channel.
// ----------------------------------------------------------------------------
module tclp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_valid,
    input  wire logic        i_ready,
    input  wire logic [1:0]  o_line_status,
    input  wire logic        o_keyword_is_settime,
    input  wire logic [13:0] o_year_value,
    input  wire logic [6:0]  o_month_value,
    input  wire logic [6:0]  o_day_value,
    input  wire logic [6:0]  o_hour_value,
    input  wire logic [6:0]  o_minute_value,
    input  wire logic [6:0]  o_second_value,
    input  wire logic        o_message_ok
);
    import tclp_pkg::*;

    // a report stays valid, with status, year and second stable, until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_line_status)
            && $stable(o_year_value) && $stable(o_second_value))
        else $error("report changed while stalled");

    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_message_ok == (o_line_status == ST_PARSED))
        else $error("message_ok disagrees with status");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_status != ST_PARSED |-> o_year_value == '0
            && o_month_value == '0 && o_day_value == '0 && o_hour_value == '0
            && o_minute_value == '0 && o_second_value == '0)
        else $error("date fields set on a report without a parse");

    a_kind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_line_status == ST_NOT_CMD || o_line_status == ST_OVERFLOW)
            |-> !o_keyword_is_settime)
        else $error("keyword kind set on a non-command report");

    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_valid)
        else $error("report pending straight after reset");

endmodule

bind time_command_line_parser tclp_checker u_tclp_checker (.*);
`default_nettype wire
